FILE: rtl/elas_pkg.sv
// ----------------------------------------------------------------------------
// elas_pkg: shared types and constants for the exponent limits and stride block
// Lane counts, widths and the queue entry passed from front to back.
// ----------------------------------------------------------------------------
package elas_pkg;

	localparam int NVARS = 4;
	localparam int EXP_BITS = 16;
	localparam int LANE_STRIDE = 16;
	localparam int VAR_W = 2;
	localparam int CFG_W = 3;
	localparam int CNT_W = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;
	localparam int QDEPTH = 2;

	localparam logic MODE_LIMITS = 1'b0;
	localparam logic MODE_STRIDE = 1'b1;

	// classified term as it travels through the queue
	typedef struct packed {
		logic mode;
		logic sel;
		logic first;
		logic last;
		logic [NVARS*LANE_STRIDE-1:0] exps;
		logic [2:0] nvars;
	} term_t;

	typedef struct packed {
		logic kind;
		logic [VAR_W-1:0] var_index;
		logic [15:0] min_exp;
		logic [15:0] max_exp;
		logic [15:0] min_count;
		logic [15:0] max_count;
		logic [15:0] stride;
		logic final_res;
	} result_t;

endpackage

FILE: rtl/elas_if.sv
// ----------------------------------------------------------------------------
// term_if / result_if: valid/ready channels of the block
// Input terms and output results with source and sink modports.
// ----------------------------------------------------------------------------
interface term_if;
	logic valid;
	logic ready;
	logic mode;
	logic poly_sel;
	logic first;
	logic last;
	logic [63:0] exponents;
	modport source (output valid, mode, poly_sel, first, last, exponents, input ready);
	modport sink (input valid, mode, poly_sel, first, last, exponents, output ready);
endinterface

interface result_if;
	logic valid;
	logic ready;
	logic kind;
	logic [1:0] var_index;
	logic [15:0] min_exp;
	logic [15:0] max_exp;
	logic [15:0] min_count;
	logic [15:0] max_count;
	logic [15:0] stride;
	logic final_res;
	modport source (output valid, kind, var_index, min_exp, max_exp, min_count,
		max_count, stride, final_res, input ready);
	modport sink (input valid, kind, var_index, min_exp, max_exp, min_count,
		max_count, stride, final_res, output ready);
endinterface

FILE: rtl/exponent_limits_and_stride.sv
// ----------------------------------------------------------------------------
// exponent_limits_and_stride: exponent limits and gcd stride of two polynomials
// Top level joining the term queue front and the execution back.
// ----------------------------------------------------------------------------
// Usage:
//   term input channel (in) carries one polynomial term per transaction;
//   result channel (out) carries one result per variable in use.
//   write vars_in_use (cfg_we/cfg_wdata) only while idle; nothing checks it.
// Execution:
//   a limits term is applied as it is popped in idle; a stride term runs
//   the per-lane iterative binary gcd units (one step per cycle over 16-bit
//   values); a seeding term runs the gcd twice; a stride term after the pass
//   finished early runs no gcd. No new term is popped until the last one is
//   done. Results leave one per cycle while out.ready is high.
// Reset:
//   all limits, counts and strides clear to zero; vars_in_use returns to 4.
// Stall:
//   a stalled receiver holds the current result; the two-entry term queue
//   keeps taking terms until it is full, then in.ready drops.
// ----------------------------------------------------------------------------
module exponent_limits_and_stride (
	input  logic clk,
	input  logic arst_n,
	term_if.sink in,
	result_if.source out,
	input  logic cfg_we,
	input  logic [elas_pkg::CFG_W-1:0] cfg_wdata
);

	logic [elas_pkg::CFG_W-1:0] vars_q;
	logic q_valid, q_pop;
	elas_pkg::term_t q_head;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vars_q <= 3'd4;
		else if (cfg_we) vars_q <= cfg_wdata;
	end

	elas_front u_front (.clk(clk), .arst_n(arst_n), .in(in), .vars_in_use(vars_q),
		.q_valid(q_valid), .q_pop(q_pop), .q_head(q_head));

	elas_back u_back (.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop),
		.q_head(q_head), .out(out));

	// result holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> out.valid && $stable(out.var_index))
		else $error("result changed under stall");

	// never pop an empty queue
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

	// stride results carry no limits
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.kind |-> out.min_exp == 16'd0 && out.max_count == 16'd0)
		else $error("limits in stride result");

endmodule

FILE: rtl/elas_front.sv
// ----------------------------------------------------------------------------
// elas_front: accepts terms, clamps the variable count and queues them
// Two-entry queue lets the front keep taking terms while the back works.
// ----------------------------------------------------------------------------
module elas_front (
	input  logic clk,
	input  logic arst_n,
	term_if.sink in,
	input  logic [elas_pkg::CFG_W-1:0] vars_in_use,
	output logic q_valid,
	input  logic q_pop,
	output elas_pkg::term_t q_head
);

	elas_pkg::term_t mem_q [elas_pkg::QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;
	logic [2:0] nv;
	elas_pkg::term_t t;

	// clamp register to 1..NVARS
	always_comb begin
		if (vars_in_use == 3'd0) nv = 3'd1;
		else if (vars_in_use > 3'(elas_pkg::NVARS)) nv = 3'(elas_pkg::NVARS);
		else nv = vars_in_use;
		t.mode = in.mode;
		t.sel = in.poly_sel;
		t.first = in.first;
		t.last = in.last;
		t.exps = in.exponents;
		t.nvars = nv;
	end

	assign in.ready = (cnt_q != 2'd2);
	assign push = in.valid && in.ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_head = mem_q[rp_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= t;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

FILE: rtl/elas_gcd.sv
// ----------------------------------------------------------------------------
// elas_gcd: iterative binary gcd of two 16-bit values
// One subtract-and-shift step a cycle until one operand reaches zero.
// ----------------------------------------------------------------------------
module elas_gcd (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [15:0] a,
	input  logic [15:0] b,
	output logic busy,
	output logic [15:0] res
);

	logic [15:0] x_q, y_q;
	logic [4:0] k_q;
	logic busy_q;

	assign busy = busy_q;

	// step engine: strip common twos, then subtract odd values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			k_q <= '0;
			res <= '0;
		end else if (start) begin
			x_q <= a;
			y_q <= b;
			k_q <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (x_q == 16'd0) begin
				res <= y_q << k_q;
				busy_q <= 1'b0;
			end else if (y_q == 16'd0) begin
				res <= x_q << k_q;
				busy_q <= 1'b0;
			end else if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + 5'd1;
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q >= y_q) begin
				x_q <= (x_q - y_q) >> 1;
			end else begin
				y_q <= (y_q - x_q) >> 1;
			end
		end
	end

endmodule

FILE: rtl/elas_back.sv
// ----------------------------------------------------------------------------
// elas_back: executes queued terms and emits results
// Limits update as the term is popped; stride terms run lane gcd units in parallel.
// ----------------------------------------------------------------------------
module elas_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_pop,
	input  elas_pkg::term_t q_head,
	result_if.source out
);

	typedef enum logic [2:0] {S_IDLE, S_SEED, S_SEEDW, S_FOLD, S_FOLDW, S_EMIT}
		state_t;

	localparam int NV = elas_pkg::NVARS;

	state_t st_q;
	logic [15:0] amin_q [NV];
	logic [15:0] amax_q [NV];
	logic [15:0] bmin_q [NV];
	logic [15:0] bmax_q [NV];
	logic [15:0] minh_q [NV];
	logic [15:0] maxh_q [NV];
	logic [15:0] acc_q [NV];
	logic done_q;
	elas_pkg::term_t cur_q;
	logic [elas_pkg::VAR_W-1:0] idx_q;
	logic [2:0] n_q;
	logic kind_q;
	logic start;
	logic [15:0] ga [NV];
	logic [15:0] gb [NV];
	logic [15:0] gr [NV];
	logic [NV-1:0] gbusy;
	logic [15:0] xl [NV];
	logic [15:0] xm [NV];

	assign q_pop = (st_q == S_IDLE) && q_valid;

	// lane extraction and gcd operands
	always_comb begin
		for (int j = 0; j < NV; j++) begin
			xl[j] = cur_q.exps[j*elas_pkg::LANE_STRIDE +: elas_pkg::EXP_BITS];
			xm[j] = cur_q.sel ? bmin_q[j] : amin_q[j];
			if (st_q == S_SEED) begin
				ga[j] = amax_q[j] - amin_q[j];
				gb[j] = bmax_q[j] - bmin_q[j];
			end else begin
				ga[j] = acc_q[j];
				gb[j] = xl[j] - xm[j];
			end
		end
	end

	assign start = (st_q == S_SEED) || (st_q == S_FOLD);

	for (genvar g = 0; g < NV; g++) begin : g_lane
		elas_gcd u_gcd (.clk(clk), .arst_n(arst_n), .start(start),
			.a(ga[g]), .b(gb[g]), .busy(gbusy[g]), .res(gr[g]));
	end

	// result payload
	assign out.valid = (st_q == S_EMIT);
	assign out.kind = kind_q;
	assign out.var_index = idx_q;
	assign out.min_exp = kind_q ? 16'd0 : (cur_q.sel ? bmin_q[idx_q] : amin_q[idx_q]);
	assign out.max_exp = kind_q ? 16'd0 : (cur_q.sel ? bmax_q[idx_q] : amax_q[idx_q]);
	assign out.min_count = kind_q ? 16'd0 : minh_q[idx_q];
	assign out.max_count = kind_q ? 16'd0 : maxh_q[idx_q];
	assign out.stride = kind_q ? acc_q[idx_q] : 16'd0;
	assign out.final_res = ({1'b0, idx_q} == n_q - 3'd1);

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done_q <= 1'b0;
			idx_q <= '0;
			n_q <= 3'd1;
			kind_q <= 1'b0;
			cur_q <= '0;
			for (int j = 0; j < NV; j++) begin
				amin_q[j] <= '0; amax_q[j] <= '0;
				bmin_q[j] <= '0; bmax_q[j] <= '0;
				minh_q[j] <= '0; maxh_q[j] <= '0;
				acc_q[j] <= '0;
			end
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						cur_q <= q_head;
						n_q <= q_head.nvars;
						idx_q <= '0;
						kind_q <= q_head.mode;
						if (q_head.mode == elas_pkg::MODE_LIMITS) begin
							for (int j = 0; j < NV; j++) begin
								if (j < int'(q_head.nvars)) begin
									logic [15:0] x, mn, mx;
									x = q_head.exps[j*elas_pkg::LANE_STRIDE +:
										elas_pkg::EXP_BITS];
									mn = q_head.sel ? bmin_q[j] : amin_q[j];
									mx = q_head.sel ? bmax_q[j] : amax_q[j];
									if (q_head.first || x < mn) begin
										if (q_head.sel) bmin_q[j] <= x; else amin_q[j] <= x;
										minh_q[j] <= 16'd1;
									end else if (x == mn && minh_q[j] != elas_pkg::CNT_MAX)
										minh_q[j] <= minh_q[j] + 16'd1;
									if (q_head.first || x > mx) begin
										if (q_head.sel) bmax_q[j] <= x; else amax_q[j] <= x;
										maxh_q[j] <= 16'd1;
									end else if (x == mx && maxh_q[j] != elas_pkg::CNT_MAX)
										maxh_q[j] <= maxh_q[j] + 16'd1;
								end
							end
							if (q_head.last) st_q <= S_EMIT;
						end else if (!q_head.sel && q_head.first) begin
							st_q <= S_SEED;
						end else if (!done_q) begin
							st_q <= S_FOLD;
						end else if (q_head.sel && q_head.last) begin
							st_q <= S_EMIT;
						end
					end
				end
				S_SEED: st_q <= S_SEEDW;
				S_SEEDW: begin
					if (gbusy == '0) begin
						for (int j = 0; j < NV; j++)
							if (j < int'(n_q)) acc_q[j] <= gr[j];
						done_q <= 1'b0;
						st_q <= S_FOLD;
					end
				end
				S_FOLD: st_q <= S_FOLDW;
				S_FOLDW: begin
					if (gbusy == '0) begin
						for (int j = 0; j < NV; j++)
							if (j < int'(n_q)) acc_q[j] <= gr[j];
						begin
							logic [15:0] o;
							o = '0;
							for (int j = 0; j < NV; j++)
								if (j < int'(n_q)) o = o | gr[j];
							if (o < 16'd2) done_q <= 1'b1;
						end
						st_q <= (cur_q.sel && cur_q.last) ? S_EMIT : S_IDLE;
					end
				end
				S_EMIT: begin
					if (out.ready) begin
						if ({1'b0, idx_q} == n_q - 3'd1) st_q <= S_IDLE;
						else idx_q <= idx_q + 1'b1;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule
